/* rtl/core/tbpp_pkg.sv */
`timescale 1ns / 1ps

package tbpp_pkg;

   // field widths
   localparam int TS_W       = 64;
   localparam int LEN_W      = 16;
   localparam int CNT_W      = 48;
   localparam int TOK_W      = 32;
   localparam int HALF_W     = 32;
   localparam int PROD_W     = TOK_W + TS_W;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LIMIT_ENABLE = 2'd0,
      CSR_RATE         = 2'd1,
      CSR_BURST        = 2'd2
   } csr_index_type;

   // refill saturates once rate * elapsed reaches 2^32 * 1e9
   localparam logic [PROD_W-1:0] SAT_LIMIT = 96'd4294967296000000000;

   // 1e9 = 2^9 * 5^9: shift out the power of two, then divide by 5^9
   localparam int DIV_SHIFT = 9;
   localparam int QX_W      = 53;
   localparam int QX_HI_W   = QX_W - HALF_W;
   localparam int ODD_W     = 21;
   localparam logic [ODD_W-1:0] DIV_ODD = 21'd1953125;

   // floor(2^53 / 5^9), estimate is low by at most one
   localparam int RECIP_W     = 33;
   localparam int RECIP_SHIFT = 53;
   localparam logic [RECIP_W-1:0] RECIP = 33'd4611686018;

   localparam int MLO_W = HALF_W + RECIP_W;
   localparam int MHI_W = QX_HI_W + RECIP_W;
   localparam int MSUM_W = MHI_W + HALF_W + 1;

endpackage

/* rtl/core/tbpp_req_if.sv */
`timescale 1ns / 1ps

interface tbpp_req_if;
   import tbpp_pkg::*;

   logic              valid;
   logic              ready;
   logic [TS_W-1:0]   timestamp_ns;
   logic [LEN_W-1:0]  packet_bytes;

   modport source (output valid, output timestamp_ns, output packet_bytes, input ready);
   modport sink   (input valid, input timestamp_ns, input packet_bytes, output ready);
endinterface

/* rtl/core/tbpp_rsp_if.sv */
`timescale 1ns / 1ps

interface tbpp_rsp_if;
   import tbpp_pkg::*;

   logic              valid;
   logic              ready;
   logic              allow;
   logic [CNT_W-1:0]  passed_count;
   logic [CNT_W-1:0]  dropped_count;
   logic [CNT_W-1:0]  bytes_seen;

   modport source (output valid, output allow, output passed_count, output dropped_count,
                   output bytes_seen, input ready);
   modport sink   (input valid, input allow, input passed_count, input dropped_count,
                   input bytes_seen, output ready);
endinterface

/* rtl/core/token_bucket_packet_policer.sv */
`timescale 1ns / 1ps
// path: stage a loads on the request transfer edge, stages b to h follow, then the result
//   register makes the result valid
// throughput: one packet per cycle while the result channel is ready; the refill math is
//   pipelined and only the bucket add / cap / subtract sits in the feedback loop of the last stage
// reset: synchronous, active high; clears configuration, bucket, timestamps, counters
//   and all valid flags; payload registers are not reset

module token_bucket_packet_policer (
   input  logic                              clock,
   input  logic                              reset,
   tbpp_req_if.sink                          req_ch,
   tbpp_rsp_if.source                        rsp_ch,
   input  logic                              csr_wr_en,
   input  logic [tbpp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tbpp_pkg::CSR_DATA_W-1:0]   csr_wr_data
);
   import tbpp_pkg::*;

   // configuration registers
   logic                limit_enable_ff;
   logic [TOK_W-1:0]    rate_ff;
   logic [TOK_W-1:0]    burst_ff;

   // timestamp tracking at the input
   logic                ts_started_ff;
   logic [TS_W-1:0]     last_ts_ff;

   // bucket and counters
   logic [TOK_W-1:0]    tokens_ff;
   logic [TOK_W-1:0]    tokens_in;
   logic [CNT_W-1:0]    pass_cnt_ff;
   logic [CNT_W-1:0]    pass_cnt_in;
   logic [CNT_W-1:0]    drop_cnt_ff;
   logic [CNT_W-1:0]    drop_cnt_in;
   logic [CNT_W-1:0]    byte_cnt_ff;
   logic [CNT_W-1:0]    byte_cnt_in;
   logic                allow_in;

   // stage a: elapsed time
   logic                a_v_ff;
   logic [TS_W-1:0]     a_elapsed_ff;
   logic [TS_W-1:0]     a_elapsed_in;
   logic [LEN_W-1:0]    a_len_ff;
   logic                a_first_ff;

   // stage b: rate times each half of elapsed
   logic                b_v_ff;
   logic [2*HALF_W-1:0] b_plo_ff;
   logic [2*HALF_W-1:0] b_phi_ff;
   logic [LEN_W-1:0]    b_len_ff;
   logic                b_first_ff;

   // stage c: full product
   logic                c_v_ff;
   logic [PROD_W-1:0]   c_prod_ff;
   logic [LEN_W-1:0]    c_len_ff;
   logic                c_first_ff;

   // stage d: saturation check, shifted dividend
   logic                d_v_ff;
   logic                d_sat_ff;
   logic [QX_W-1:0]     d_x_ff;
   logic [LEN_W-1:0]    d_len_ff;
   logic                d_first_ff;

   // stage e: reciprocal partial products
   logic                e_v_ff;
   logic                e_sat_ff;
   logic [QX_W-1:0]     e_x_ff;
   logic [MLO_W-1:0]    e_mlo_ff;
   logic [MHI_W-1:0]    e_mhi_ff;
   logic [LEN_W-1:0]    e_len_ff;
   logic                e_first_ff;

   // stage f: quotient estimate
   logic                f_v_ff;
   logic                f_sat_ff;
   logic [QX_W-1:0]     f_x_ff;
   logic [TOK_W-1:0]    f_q_ff;
   logic [MSUM_W-1:0]   f_sum;
   logic [LEN_W-1:0]    f_len_ff;
   logic                f_first_ff;

   // stage g: estimate times divisor
   logic                g_v_ff;
   logic                g_sat_ff;
   logic [QX_W-1:0]     g_x_ff;
   logic [TOK_W-1:0]    g_q_ff;
   logic [QX_W-1:0]     g_qd_ff;
   logic [LEN_W-1:0]    g_len_ff;
   logic                g_first_ff;

   // stage h: corrected, saturated refill amount
   logic                h_v_ff;
   logic [TOK_W-1:0]    h_add_ff;
   logic [TOK_W-1:0]    h_add_in;
   logic [QX_W-1:0]     g_rem;
   logic [LEN_W-1:0]    h_len_ff;
   logic                h_first_ff;

   // result register
   logic                rsp_valid_ff;
   logic                rsp_allow_ff;
   logic [CNT_W-1:0]    rsp_passed_ff;
   logic [CNT_W-1:0]    rsp_dropped_ff;
   logic [CNT_W-1:0]    rsp_bytes_ff;

   // stage can take new data when empty or when it moves on this cycle
   logic open_a, open_b, open_c, open_d, open_e, open_f, open_g, open_h, open_rsp;
   logic req_xfer;

   // bucket stage scratch
   logic [TOK_W-1:0]    bkt_base;
   logic [TOK_W:0]      bkt_sum;
   logic [TOK_W-1:0]    bkt_capped;
   logic                bkt_fits;

   assign open_rsp = !rsp_valid_ff || rsp_ch.ready;
   assign open_h   = !h_v_ff || open_rsp;
   assign open_g   = !g_v_ff || open_h;
   assign open_f   = !f_v_ff || open_g;
   assign open_e   = !e_v_ff || open_f;
   assign open_d   = !d_v_ff || open_e;
   assign open_c   = !c_v_ff || open_d;
   assign open_b   = !b_v_ff || open_c;
   assign open_a   = !a_v_ff || open_b;

   assign req_ch.ready = open_a;
   assign req_xfer     = req_ch.valid && open_a;

   // ---------------------------------------------------------------
   // configuration writes; unknown indexes are dropped
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_enable_ff <= 1'b0;
         rate_ff         <= '0;
         burst_ff        <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_LIMIT_ENABLE: limit_enable_ff <= csr_wr_data[0];
            CSR_RATE:         rate_ff         <= csr_wr_data[TOK_W-1:0];
            CSR_BURST:        burst_ff        <= csr_wr_data[TOK_W-1:0];
            default:          ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // input side: elapsed time since the last enabled packet
   // the very first enabled packet sees zero elapsed and fills the bucket
   // ---------------------------------------------------------------
   assign a_elapsed_in = ts_started_ff ? (req_ch.timestamp_ns - last_ts_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         ts_started_ff <= 1'b0;
         last_ts_ff    <= '0;
      end else if (req_xfer && limit_enable_ff) begin
         ts_started_ff <= 1'b1;
         last_ts_ff    <= req_ch.timestamp_ns;
      end
   end

   // ---------------------------------------------------------------
   // refill pipeline: floor(rate * elapsed / 1e9), saturated to 32 bits
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
         d_v_ff <= 1'b0;
         e_v_ff <= 1'b0;
         f_v_ff <= 1'b0;
         g_v_ff <= 1'b0;
         h_v_ff <= 1'b0;
      end else begin
         if (open_a) a_v_ff <= req_ch.valid;
         if (open_b) b_v_ff <= a_v_ff;
         if (open_c) c_v_ff <= b_v_ff;
         if (open_d) d_v_ff <= c_v_ff;
         if (open_e) e_v_ff <= d_v_ff;
         if (open_f) f_v_ff <= e_v_ff;
         if (open_g) g_v_ff <= f_v_ff;
         if (open_h) h_v_ff <= g_v_ff;
      end
   end

   // stage a
   always_ff @(posedge clock) begin
      if (open_a) begin
         a_elapsed_ff <= a_elapsed_in;
         a_len_ff     <= req_ch.packet_bytes;
         a_first_ff   <= !ts_started_ff;
      end
   end

   // stage b: two 32x32 products
   always_ff @(posedge clock) begin
      if (open_b) begin
         b_plo_ff   <= (2*HALF_W)'(rate_ff) * (2*HALF_W)'(a_elapsed_ff[HALF_W-1:0]);
         b_phi_ff   <= (2*HALF_W)'(rate_ff) * (2*HALF_W)'(a_elapsed_ff[TS_W-1:HALF_W]);
         b_len_ff   <= a_len_ff;
         b_first_ff <= a_first_ff;
      end
   end

   // stage c: combine into the full product
   always_ff @(posedge clock) begin
      if (open_c) begin
         c_prod_ff  <= {b_phi_ff, {HALF_W{1'b0}}} + PROD_W'(b_plo_ff);
         c_len_ff   <= b_len_ff;
         c_first_ff <= b_first_ff;
      end
   end

   // stage d: below the limit the product fits 62 bits; drop the factor 2^9
   always_ff @(posedge clock) begin
      if (open_d) begin
         d_sat_ff   <= (c_prod_ff >= SAT_LIMIT);
         d_x_ff     <= c_prod_ff[QX_W+DIV_SHIFT-1:DIV_SHIFT];
         d_len_ff   <= c_len_ff;
         d_first_ff <= c_first_ff;
      end
   end

   // stage e: dividend times reciprocal of 5^9, in two pieces
   always_ff @(posedge clock) begin
      if (open_e) begin
         e_mlo_ff   <= MLO_W'(d_x_ff[HALF_W-1:0]) * MLO_W'(RECIP);
         e_mhi_ff   <= MHI_W'(d_x_ff[QX_W-1:HALF_W]) * MHI_W'(RECIP);
         e_sat_ff   <= d_sat_ff;
         e_x_ff     <= d_x_ff;
         e_len_ff   <= d_len_ff;
         e_first_ff <= d_first_ff;
      end
   end

   // stage f: quotient estimate, exact or one low
   assign f_sum = MSUM_W'({e_mhi_ff, {HALF_W{1'b0}}}) + MSUM_W'(e_mlo_ff);

   always_ff @(posedge clock) begin
      if (open_f) begin
         f_q_ff     <= f_sum[RECIP_SHIFT+TOK_W-1:RECIP_SHIFT];
         f_sat_ff   <= e_sat_ff;
         f_x_ff     <= e_x_ff;
         f_len_ff   <= e_len_ff;
         f_first_ff <= e_first_ff;
      end
   end

   // stage g: back-multiply for the remainder check
   always_ff @(posedge clock) begin
      if (open_g) begin
         g_qd_ff    <= QX_W'(f_q_ff) * QX_W'(DIV_ODD);
         g_q_ff     <= f_q_ff;
         g_sat_ff   <= f_sat_ff;
         g_x_ff     <= f_x_ff;
         g_len_ff   <= f_len_ff;
         g_first_ff <= f_first_ff;
      end
   end

   // stage h: remainder of a full divisor or more means the estimate was one low
   assign g_rem    = g_x_ff - g_qd_ff;
   assign h_add_in = g_sat_ff ? {TOK_W{1'b1}} :
                     (g_rem >= QX_W'(DIV_ODD)) ? (g_q_ff + TOK_W'(1)) : g_q_ff;

   always_ff @(posedge clock) begin
      if (open_h) begin
         h_add_ff   <= h_add_in;
         h_len_ff   <= g_len_ff;
         h_first_ff <= g_first_ff;
      end
   end

   // ---------------------------------------------------------------
   // bucket stage: fill on first packet, refill, cap at burst, check length
   // when limiting is off the packet passes and nothing moves
   // ---------------------------------------------------------------
   always_comb begin
      bkt_base    = h_first_ff ? burst_ff : tokens_ff;
      bkt_sum     = {1'b0, bkt_base} + {1'b0, h_add_ff};
      bkt_capped  = (bkt_sum > {1'b0, burst_ff}) ? burst_ff : bkt_sum[TOK_W-1:0];
      bkt_fits    = (bkt_capped >= TOK_W'(h_len_ff));

      tokens_in   = tokens_ff;
      pass_cnt_in = pass_cnt_ff;
      drop_cnt_in = drop_cnt_ff;
      byte_cnt_in = byte_cnt_ff;
      allow_in    = 1'b1;

      if (limit_enable_ff) begin
         byte_cnt_in = byte_cnt_ff + CNT_W'(h_len_ff);
         allow_in    = bkt_fits;
         if (bkt_fits) begin
            tokens_in   = bkt_capped - TOK_W'(h_len_ff);
            pass_cnt_in = pass_cnt_ff + CNT_W'(1);
         end else begin
            tokens_in   = bkt_capped;
            drop_cnt_in = drop_cnt_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tokens_ff   <= '0;
         pass_cnt_ff <= '0;
         drop_cnt_ff <= '0;
         byte_cnt_ff <= '0;
      end else if (open_rsp && h_v_ff) begin
         tokens_ff   <= tokens_in;
         pass_cnt_ff <= pass_cnt_in;
         drop_cnt_ff <= drop_cnt_in;
         byte_cnt_ff <= byte_cnt_in;
      end
   end

   // ---------------------------------------------------------------
   // result register; holds until the transfer completes
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (open_rsp) begin
         rsp_valid_ff <= h_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (open_rsp && h_v_ff) begin
         rsp_allow_ff   <= allow_in;
         rsp_passed_ff  <= pass_cnt_in;
         rsp_dropped_ff <= drop_cnt_in;
         rsp_bytes_ff   <= byte_cnt_in;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.allow         = rsp_allow_ff;
   assign rsp_ch.passed_count  = rsp_passed_ff;
   assign rsp_ch.dropped_count = rsp_dropped_ff;
   assign rsp_ch.bytes_seen    = rsp_bytes_ff;

endmodule

/* rtl/core/tbpp_checker.sv */
`timescale 1ns / 1ps

module tbpp_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic                       rsp_allow,
   input logic [tbpp_pkg::CNT_W-1:0] rsp_passed_count,
   input logic [tbpp_pkg::CNT_W-1:0] rsp_dropped_count,
   input logic [tbpp_pkg::CNT_W-1:0] rsp_bytes_seen
);
   import tbpp_pkg::*;

   logic             rsp_xfer;
   logic [CNT_W-1:0] prev_pass_ff;
   logic [CNT_W-1:0] prev_drop_ff;
   logic [CNT_W-1:0] prev_bytes_ff;

   assign rsp_xfer = rsp_valid && rsp_ready;

   // counters as last seen on the result channel
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_pass_ff  <= '0;
         prev_drop_ff  <= '0;
         prev_bytes_ff <= '0;
      end else if (rsp_xfer) begin
         prev_pass_ff  <= rsp_passed_count;
         prev_drop_ff  <= rsp_dropped_count;
         prev_bytes_ff <= rsp_bytes_seen;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_allow)
         && $stable(rsp_passed_count) && $stable(rsp_dropped_count) && $stable(rsp_bytes_seen))
      else $error("result changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_drop_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && !rsp_allow |->
         rsp_dropped_count == CNT_W'(prev_drop_ff + CNT_W'(1))
         && rsp_passed_count == prev_pass_ff)
      else $error("drop not counted once");

   a_pass_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && rsp_allow |->
         rsp_dropped_count == prev_drop_ff
         && (rsp_passed_count == prev_pass_ff
             || rsp_passed_count == CNT_W'(prev_pass_ff + CNT_W'(1))))
      else $error("pass counter moved wrongly");

   a_bypass_still: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && rsp_passed_count == prev_pass_ff && rsp_dropped_count == prev_drop_ff |->
         rsp_bytes_seen == prev_bytes_ff)
      else $error("byte counter moved on a bypassed packet");

endmodule

bind token_bucket_packet_policer tbpp_checker u_tbpp_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_allow         (rsp_ch.allow),
   .rsp_passed_count  (rsp_ch.passed_count),
   .rsp_dropped_count (rsp_ch.dropped_count),
   .rsp_bytes_seen    (rsp_ch.bytes_seen)
);

/* tb/sv/token_bucket_packet_policer_tb.sv */
`timescale 1ns / 1ps

module token_bucket_packet_policer_tb;
   import tbpp_pkg::*;

   // generous ceiling, well above what it takes for every packet to wait out the longest sender
   // gap and receiver stall
   localparam int CYCLE_LIMIT  = 250000;
   // request transfer to result valid
   localparam int PIPE_LATENCY = 8;
   localparam int POLICY_PHASES = 9;

   // index one past the register list, the block must ignore writes to it
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam logic [PROD_W-1:0]    NS_PER_SEC = 96'd1000000000;
   localparam logic [TOK_W-1:0]     TOK_MAX    = {TOK_W{1'b1}};

   // one policing decision as the result channel reports it
   typedef struct packed {
      logic              allow;
      logic [CNT_W-1:0]  passed;
      logic [CNT_W-1:0]  dropped;
      logic [CNT_W-1:0]  bytes;
   } verdict_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   tbpp_req_if req_ch ();
   tbpp_rsp_if rsp_ch ();

   token_bucket_packet_policer dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // policer image kept by the bench: registers as last written
   logic              cfg_enable;
   logic [TOK_W-1:0]  cfg_rate;
   logic [TOK_W-1:0]  cfg_burst;
   // bucket state and counters
   logic [TOK_W-1:0]  bucket_level;
   logic [TS_W-1:0]   last_stamp;
   logic              bucket_live;
   logic [CNT_W-1:0]  n_passed;
   logic [CNT_W-1:0]  n_dropped;
   logic [CNT_W-1:0]  n_bytes;

   // decisions predicted for accepted packets, oldest first
   verdict_type pending_verdicts[$];
   verdict_type head;

   int error_count   = 0;
   int packets_sent  = 0;
   int seen_allow    = 0;
   int seen_drop     = 0;

   // receiver stall pattern knobs, the sender gap limit, and the stimulus time cursor
   int stall_pct      = 0;
   int max_stall      = 1;
   int stall_left     = 0;
   int sender_gap_max = 0;
   logic [TS_W-1:0] now_ns;

   // floor(rate * elapsed / 1e9) formed at full width, clipped to the token width
   function automatic logic [TOK_W-1:0] refill_tokens(input logic [TOK_W-1:0] rate,
                                                      input logic [TS_W-1:0] elapsed);
      logic [PROD_W-1:0] whole;
      whole = ({{TS_W{1'b0}}, rate} * {{TOK_W{1'b0}}, elapsed}) / NS_PER_SEC;
      if (whole > {{TS_W{1'b0}}, TOK_MAX})
         return TOK_MAX;
      return whole[TOK_W-1:0];
   endfunction

   // advance the bench's bucket by one packet and return the decision it should produce
   function automatic verdict_type police_packet(input logic [TS_W-1:0] ts,
                                                 input logic [LEN_W-1:0] len);
      verdict_type v;
      logic [TOK_W:0] level;
      v.allow = 1'b1;
      if (cfg_enable) begin
         // first enabled packet starts with a full bucket
         if (!bucket_live) begin
            bucket_level = cfg_burst;
            last_stamp   = ts;
            bucket_live  = 1'b1;
         end
         n_bytes = n_bytes + CNT_W'(len);
         // elapsed time wraps at 64 bits, so a stamp going back reads as a huge gap
         level = {1'b0, bucket_level} + {1'b0, refill_tokens(cfg_rate, ts - last_stamp)};
         if (level > {1'b0, cfg_burst})
            level = {1'b0, cfg_burst};
         bucket_level = level[TOK_W-1:0];
         last_stamp   = ts;
         if (bucket_level >= TOK_W'(len)) begin
            bucket_level = bucket_level - TOK_W'(len);
            n_passed     = n_passed + CNT_W'(1);
         end else begin
            n_dropped = n_dropped + CNT_W'(1);
            v.allow   = 1'b0;
         end
      end
      v.passed  = n_passed;
      v.dropped = n_dropped;
      v.bytes   = n_bytes;
      return v;
   endfunction

   task automatic flag_error(input string what);
      $display("ERROR @%0t: %s", $realtime, what);
      error_count++;
   endtask

   // one packet transfer: drive at the falling edge, hold until the block takes it
   task automatic send_packet(input logic [TS_W-1:0] ts, input logic [LEN_W-1:0] len);
      @(negedge clock);
      req_ch.valid        = 1'b1;
      req_ch.timestamp_ns = ts;
      req_ch.packet_bytes = len;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      pending_verdicts.push_back(police_packet(ts, len));
      packets_sent++;
   endtask

   task automatic release_req;
      @(negedge clock);
      req_ch.valid = 1'b0;
   endtask

   task automatic idle_sender(input int cycles);
      if (cycles > 0) begin
         release_req();
         repeat (cycles - 1)
            @(negedge clock);
      end
   endtask

   // hold the sender off until every outstanding decision has come back
   task automatic wait_for_results;
      release_req();
      while (pending_verdicts.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_index   = idx;
      csr_wr_data = data;
      @(negedge clock);
      csr_wr_en = 1'b0;
      case (idx)
         CSR_LIMIT_ENABLE: cfg_enable = data[0];
         CSR_RATE:         cfg_rate   = data;
         CSR_BURST:        cfg_burst  = data;
         default: ;
      endcase
   endtask

   // registers only change with the pipe empty
   task automatic set_policy(input logic en, input logic [TOK_W-1:0] rate,
                             input logic [TOK_W-1:0] burst);
      wait_for_results();
      write_reg(CSR_LIMIT_ENABLE, {{(CSR_DATA_W-1){1'b0}}, en});
      write_reg(CSR_RATE, rate);
      write_reg(CSR_BURST, burst);
   endtask

   // mostly forward steps of up to 2^span_bits ns, with some silences and stamps going back
   function automatic logic [TS_W-1:0] next_stamp(input int span_bits);
      int pick;
      logic [TS_W-1:0] step;
      pick = $urandom_range(99);
      step = {$urandom, $urandom};
      if (pick < 3)
         now_ns = {$urandom, $urandom};
      else if (pick < 6)
         now_ns = now_ns - (step >> $urandom_range(63, 40));
      else if (pick < 9)
         now_ns = now_ns + (step >> $urandom_range(40, 20));
      else
         now_ns = now_ns + (step >> (TS_W - span_bits));
      return now_ns;
   endfunction

   // empty and jumbo lengths, typical frames, and anything in the field
   function automatic logic [LEN_W-1:0] pick_length();
      int pick;
      pick = $urandom_range(99);
      if (pick < 5)
         return '0;
      if (pick < 10)
         return '1;
      if (pick < 45)
         return LEN_W'($urandom_range(1518, 40));
      return LEN_W'($urandom);
   endfunction

   // bursts of packets with random gaps, now and then a full hold-off until the pipe drains
   task automatic run_traffic(input int count, input int span_bits);
      int sent;
      int burst;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(24, 1);
         for (int k = 0; k < burst && sent < count; k++) begin
            send_packet(next_stamp(span_bits), pick_length());
            sent++;
         end
         if ($urandom_range(29) == 0)
            wait_for_results();
         else if (sender_gap_max > 0 && $urandom_range(1) == 1)
            idle_sender($urandom_range(sender_gap_max, 1));
      end
   endtask

   // out of reset limiting is off: everything passes, counters stay at zero
   task automatic test_disabled_passthrough;
      send_packet('0, '0);
      send_packet('1, '1);
      wait_for_results();
      // spare index is ignored, and only bit zero of the enable register counts
      write_reg(CSR_SPARE, '1);
      write_reg(CSR_LIMIT_ENABLE, 32'hFFFF_FFFE);
      send_packet(64'h0123_4567_89AB_CDEF, 16'd1500);
   endtask

   // first enabled packet fills the bucket; with no refill the bucket just drains
   task automatic test_first_fill;
      set_policy(1'b1, '0, 32'd3000);
      send_packet(64'd1000, 16'd1000);
      send_packet(64'd1000, 16'd1500);
      send_packet(64'd1000, 16'd501);
      send_packet(64'd1000, 16'd500);
      send_packet(64'd1000, 16'd0);
   endtask

   // full-scale rate and burst: huge gap saturates, stamp going back also refills, zero gap not
   task automatic test_refill_saturation;
      set_policy(1'b1, TOK_MAX, TOK_MAX);
      send_packet('1, '1);
      send_packet(64'd5, '1);
      send_packet(64'd5, '1);
   endtask

   // bucket is nearly full, lowering the burst cuts it at the next packet
   task automatic test_burst_lowered;
      set_policy(1'b1, '0, 32'd100);
      send_packet(64'd5, 16'd101);
      send_packet(64'd5, 16'd100);
      send_packet(64'd5, 16'd1);
   endtask

   // disabled packets leave the refill clock alone, elapsed time runs from the last enabled one
   task automatic test_reenable_gap;
      set_policy(1'b1, 32'd1000000000, 32'd5000);
      send_packet(64'd1000, 16'd5000);
      send_packet(64'd2000, 16'd900);
      wait_for_results();
      write_reg(CSR_LIMIT_ENABLE, '0);
      send_packet(64'd50000, 16'd60000);
      send_packet(64'd60000, 16'd1);
      wait_for_results();
      write_reg(CSR_LIMIT_ENABLE, 32'd1);
      send_packet(64'd62000, 16'd4999);
   endtask

   // zero burst lets only empty packets through
   task automatic test_burst_zero;
      set_policy(1'b1, TOK_MAX, '0);
      send_packet(64'd70000, 16'd0);
      send_packet(64'd80000, 16'd1);
   endtask

   // several policy settings, each with its own idling mix; phase zero runs without stalls or sender gaps
   task automatic test_random_traffic;
      logic              en;
      logic [TOK_W-1:0]  rate;
      logic [TOK_W-1:0]  burst;
      int                span;
      int                count;
      now_ns = 64'd100000;
      for (int phase = 0; phase < POLICY_PHASES; phase++) begin
         en    = 1'b1;
         count = 200;
         case (phase)
            0: begin rate = 32'd1000000000; burst = 32'd100000; span = 16; count = 220; end
            1: begin rate = 32'd125000000;  burst = 32'd20000;  span = 16; count = 220; end
            2: begin rate = $urandom; burst = $urandom; span = $urandom_range(34, 10); end
            3: begin rate = TOK_MAX; burst = TOK_MAX; span = 12; count = 150; end
            4: begin en = 1'b0; rate = $urandom; burst = $urandom; span = 16; count = 120; end
            5: begin rate = '0; burst = $urandom_range(200000); span = 20; count = 150; end
            6: begin rate = 32'd1000000; burst = 32'd3000; span = 24; end
            7: begin rate = $urandom; burst = $urandom_range(2000); span = 18; end
            default: begin
               rate  = $urandom_range(32'hFFFF_FFFF, 32'd1000000000);
               burst = 32'd65535;
               span  = 15;
            end
         endcase
         set_policy(en, rate, burst);
         if (phase == 0) begin
            stall_pct      = 0;
            sender_gap_max = 0;
         end else begin
            stall_pct      = $urandom_range(40, 5);
            max_stall      = $urandom_range(8, 1);
            sender_gap_max = $urandom_range(8, 1);
         end
         run_traffic(count, span);
      end
   endtask

   // receiver: ready most of the time, now and then a stall of random length
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_ch.ready = 1'b0;
         stall_left--;
      end else begin
         rsp_ch.ready = 1'b1;
         if ($urandom_range(99) < stall_pct)
            stall_left = $urandom_range(max_stall, 1);
      end
   end

   // every result transfer is matched against the oldest predicted decision
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_verdicts.size() == 0) begin
            flag_error($sformatf("result with no packet outstanding, allow %0b", rsp_ch.allow));
         end else begin
            head = pending_verdicts.pop_front();
            if (rsp_ch.allow)
               seen_allow++;
            else
               seen_drop++;
            if (rsp_ch.allow !== head.allow)
               flag_error($sformatf("allow %0b, want %0b", rsp_ch.allow, head.allow));
            if (rsp_ch.passed_count !== head.passed)
               flag_error($sformatf("passed_count %0d, want %0d",
                                    rsp_ch.passed_count, head.passed));
            if (rsp_ch.dropped_count !== head.dropped)
               flag_error($sformatf("dropped_count %0d, want %0d",
                                    rsp_ch.dropped_count, head.dropped));
            if (rsp_ch.bytes_seen !== head.bytes)
               flag_error($sformatf("bytes_seen %0d, want %0d", rsp_ch.bytes_seen, head.bytes));
         end
      end
   end

   // watchdog
   initial begin
      repeat (CYCLE_LIMIT)
         @(posedge clock);
      $display("token_bucket_packet_policer test failed");
      $finish;
   end

   initial begin
      // known values on the driven inputs from time zero; the receiver drives ready
      req_ch.valid        = 1'b0;
      req_ch.timestamp_ns = '0;
      req_ch.packet_bytes = '0;
      csr_wr_en           = 1'b0;
      csr_index           = CSR_LIMIT_ENABLE;
      csr_wr_data         = '0;
      // bench image matches the block after reset
      cfg_enable   = 1'b0;
      cfg_rate     = '0;
      cfg_burst    = '0;
      bucket_level = '0;
      last_stamp   = '0;
      bucket_live  = 1'b0;
      n_passed     = '0;
      n_dropped    = '0;
      n_bytes      = '0;
      now_ns       = '0;
      stall_pct    = 20;
      max_stall    = 3;

      repeat (10)
         @(negedge clock);
      reset = 1'b0;

      test_disabled_passthrough();
      test_first_fill();
      test_refill_saturation();
      test_burst_lowered();
      test_reenable_gap();
      test_burst_zero();
      test_random_traffic();

      // drain, then give stray results a chance to show up
      wait_for_results();
      repeat (PIPE_LATENCY + 8)
         @(posedge clock);

      $display("%0d packets over directed cases and %0d policy settings: %0d passed, %0d dropped",
               packets_sent, POLICY_PHASES, seen_allow, seen_drop);
      $display("settings spanned disabled, zero and full-scale rate and burst;");
      $display("stamps ran forward and back");
      if (error_count == 0)
         $display("token_bucket_packet_policer test passed");
      else
         $display("token_bucket_packet_policer test failed");
      $finish;
   end

endmodule
